// ----- hw/rtl/owtr_pkg.sv -----
// shared types, widths and constants for the one-wire temperature reader
// no dependencies

package owtr_pkg;

  localparam int unsigned TimerWidth = 20;
  localparam logic [TimerWidth-1:0] TimerMax = {TimerWidth{1'b1}};

  // conversion wait register width and the width phase limits are compared in
  localparam int unsigned ConvWidth  = 20;
  localparam int unsigned LimitWidth = (TimerWidth > ConvWidth) ? TimerWidth : ConvWidth;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 20;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgResetLow  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgResetWait = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgOneLow    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgZeroLow   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgSample    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgSlot      = 3'd5;
  localparam logic [CfgIdxWidth-1:0] CfgConvWait  = 3'd6;

  // bus commands
  localparam logic [7:0] CmdSkipRom  = 8'hCC;
  localparam logic [7:0] CmdConvert  = 8'h44;
  localparam logic [7:0] CmdReadPad  = 8'hBE;

  // byte steps of a measurement
  localparam logic [2:0] StepSkipA   = 3'd0;
  localparam logic [2:0] StepConvert = 3'd1;
  localparam logic [2:0] StepSkipB   = 3'd2;
  localparam logic [2:0] StepReadLo  = 3'd4;
  localparam logic [2:0] StepReadHi  = 3'd5;

  typedef enum logic [5:0] {
    PhIdle    = 6'b000001,
    PhRstLow  = 6'b000010,
    PhRstWait = 6'b000100,
    PhWrite   = 6'b001000,
    PhConv    = 6'b010000,
    PhRead    = 6'b100000
  } phase_e;

  function automatic logic [7:0] command_for(input logic [3:0] step);
    logic [7:0] cmd;
    unique case (step)
      4'd0:    cmd = CmdSkipRom;
      4'd1:    cmd = CmdConvert;
      4'd2:    cmd = CmdSkipRom;
      default: cmd = CmdReadPad;
    endcase
    return cmd;
  endfunction

endpackage

// ----- hw/rtl/one_wire_temperature_reader.sv -----
// one-wire temperature reader: bus sequencer, tick timer and output register
// depends on owtr_pkg
//
// channel  | dir | transfer moves                       | tdata (lowest bit up)
// s_axis   | in  | one timer tick of the bus            | start_req, bus_level, pad
// m_axis   | out | one line/status result per tick      | drive_low, busy_res,
//          |     |                                      | done_res, temp_tenths,
//          |     |                                      | raw_low, raw_high, pad
// cfg      | in  | one timing register write            | -
//
// one tick per clock while the output is not stalled: when a tick is taken,
// the sequencer state and the output register take its result together.
// a new tick is taken while the output register is empty or being drained.
// reset returns the sequencer to idle with zeroed readings and default timings.
// a stalled output holds its result and stops the input side only then.

module one_wire_temperature_reader
  import owtr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // start_req, bus_level, 6 zero bits
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [39:0]             m_axis_tdata,   // drive_low, busy_res, done_res,
                                                  // temp_tenths[15:0], raw_low[7:0],
                                                  // raw_high[7:0], 5 zero bits
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  // timing registers
  logic [11:0]           rst_low_q, rst_wait_q;
  logic [7:0]            one_low_q, zero_low_q, sample_q, slot_q;
  logic [ConvWidth-1:0]  conv_wait_q;

  // sequencer state
  phase_e                phase_q, phase_d;
  logic [TimerWidth-1:0] tick_q, tick_d;
  logic [2:0]            bit_q, bit_d;
  logic [2:0]            step_q, step_d;
  logic [7:0]            shift_q, shift_d;
  logic [7:0]            low_q, low_d;
  logic [7:0]            high_q, high_d;
  logic [15:0]           tenths_q, tenths_d;

  // output register
  logic                  out_valid_q;
  logic [39:0]           out_data_q;

  logic                  accept;
  logic                  start_req, bus_level;
  logic                  drive, busy, done;
  logic [TimerWidth-1:0] tick_inc;
  logic [LimitWidth-1:0] limit;
  logic                  phase_end;
  logic [7:0]            slot_len, sample_at, low_time;
  logic [3:0]            step_inc;
  logic [7:0]            shift_rd;
  logic [19:0]           tenths_sum;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start_req     = s_axis_tdata[0];
  assign bus_level     = s_axis_tdata[1];

  assign slot_len  = (slot_q == 8'd0) ? 8'd1 : slot_q;
  assign sample_at = (sample_q < slot_len) ? sample_q : slot_len - 8'd1;
  assign low_time  = shift_q[0] ? one_low_q : zero_low_q;
  assign step_inc  = {1'b0, step_q} + 4'd1;

  // saturating tick counter shared by all timed phases
  assign tick_inc = (tick_q == TimerMax) ? tick_q : tick_q + TimerWidth'(1);

  always_comb begin
    unique case (phase_q)
      PhRstLow:  limit = LimitWidth'(rst_low_q);
      PhRstWait: limit = LimitWidth'(rst_wait_q);
      PhConv:    limit = LimitWidth'(conv_wait_q);
      default:   limit = LimitWidth'(slot_len);
    endcase
  end

  assign phase_end = (LimitWidth'(tick_inc) >= limit) || (tick_inc == TimerMax);

  // read slot sample, taken before the slot-end bookkeeping
  assign shift_rd = (tick_q == TimerWidth'(sample_at)) ? {bus_level, shift_q[7:1]} : shift_q;

  // raw * 10 + 8 as shifts, then divide by 16
  assign tenths_sum = ({4'd0, shift_rd, low_q} << 3) + ({4'd0, shift_rd, low_q} << 1)
                    + 20'd8;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    step_d   = step_q;
    shift_d  = shift_q;
    low_d    = low_q;
    high_d   = high_q;
    tenths_d = tenths_q;
    drive    = 1'b0;
    busy     = 1'b1;
    done     = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        busy = 1'b0;
        if (start_req) begin
          phase_d = PhRstLow;
          tick_d  = '0;
          step_d  = StepSkipA;
        end
      end
      PhRstLow: begin
        drive  = 1'b1;
        tick_d = tick_inc;
        if (phase_end) begin
          phase_d = PhRstWait;
          tick_d  = '0;
        end
      end
      PhRstWait: begin
        tick_d = tick_inc;
        if (phase_end) begin
          phase_d = PhWrite;
          tick_d  = '0;
          bit_d   = '0;
          shift_d = command_for({1'b0, step_q});
        end
      end
      PhWrite: begin
        drive  = tick_q < TimerWidth'(low_time);
        tick_d = tick_inc;
        if (phase_end) begin
          tick_d  = '0;
          shift_d = {1'b0, shift_q[7:1]};
          if (bit_q != 3'd7) begin
            bit_d = bit_q + 3'd1;
          end else begin
            bit_d  = '0;
            step_d = step_inc[2:0];
            priority if (step_inc == 4'd2) begin
              phase_d = PhConv;
            end else if (step_inc >= 4'd4) begin
              step_d  = StepReadLo;
              shift_d = '0;
              phase_d = PhRead;
            end else begin
              shift_d = command_for(step_inc);
            end
          end
        end
      end
      PhConv: begin
        tick_d = tick_inc;
        if (phase_end) begin
          phase_d = PhRstLow;
          tick_d  = '0;
          step_d  = StepSkipB;
        end
      end
      PhRead: begin
        drive   = tick_q < TimerWidth'(one_low_q);
        shift_d = shift_rd;
        tick_d  = tick_inc;
        if (phase_end) begin
          tick_d = '0;
          if (bit_q != 3'd7) begin
            bit_d = bit_q + 3'd1;
          end else begin
            bit_d = '0;
            if (step_q == StepReadLo) begin
              low_d   = shift_rd;
              shift_d = '0;
              step_d  = StepReadHi;
            end else begin
              high_d   = shift_rd;
              tenths_d = tenths_sum[19:4];
              done     = 1'b1;
              phase_d  = PhIdle;
              step_d   = StepSkipA;
            end
          end
        end
      end
      default: begin
        busy    = 1'b0;
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      tick_q   <= '0;
      bit_q    <= '0;
      step_q   <= '0;
      shift_q  <= '0;
      low_q    <= '0;
      high_q   <= '0;
      tenths_q <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      step_q   <= step_d;
      shift_q  <= shift_d;
      low_q    <= low_d;
      high_q   <= high_d;
      tenths_q <= tenths_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q   <= 12'd480;
      rst_wait_q  <= 12'd480;
      one_low_q   <= 8'd2;
      zero_low_q  <= 8'd60;
      sample_q    <= 8'd12;
      slot_q      <= 8'd70;
      conv_wait_q <= ConvWidth'(750000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgResetLow:  rst_low_q   <= cfg_data_i[11:0];
        CfgResetWait: rst_wait_q  <= cfg_data_i[11:0];
        CfgOneLow:    one_low_q   <= cfg_data_i[7:0];
        CfgZeroLow:   zero_low_q  <= cfg_data_i[7:0];
        CfgSample:    sample_q    <= cfg_data_i[7:0];
        CfgSlot:      slot_q      <= cfg_data_i[7:0];
        CfgConvWait:  conv_wait_q <= cfg_data_i[ConvWidth-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {5'd0, high_d, low_d, tenths_d, done, busy, drive};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
